[rtl/core/cbd_pkg.sv]
// shared constants and types for the circular buffer deque
package cbd_pkg;

    localparam int DEPTH = 1024;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 31;

    // request codes on the mode field
    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_POP_FRONT  = 2'd1,
        MODE_PUSH_BACK  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    // what every cell of a row does on a clock edge
    typedef enum logic [1:0] {
        ROW_HOLD,
        ROW_INSERT,
        ROW_REMOVE,
        ROW_APPEND
    } t_row_op;

    typedef struct packed {
        t_row_op           op;
        logic [VAL_W-1:0]  data;
        logic [CNT_W-1:0]  count;
    } t_row_ctrl;

endpackage

[rtl/core/cbd_cell.sv]
// one storage cell of a deque row
module cbd_cell
    import cbd_pkg::*;
(
    input  logic              i_clk,
    input  t_row_ctrl         i_ctrl,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [VAL_W-1:0]  i_lower,
    input  logic [VAL_W-1:0]  i_upper,
    output logic [VAL_W-1:0]  o_value
);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            ROW_INSERT: n_value = i_lower;
            ROW_REMOVE: n_value = i_upper;
            ROW_APPEND: begin
                // only the first free cell takes the new element
                if (CNT_W'(i_index) == i_ctrl.count) begin
                    n_value = i_ctrl.data;
                end
            end
            default:    n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

[rtl/core/cbd_row.sv]
// row of cells holding the deque with one end pinned at cell zero
module cbd_row
    import cbd_pkg::*;
(
    input  logic              i_clk,
    input  t_row_ctrl         i_ctrl,
    output logic [VAL_W-1:0]  o_head
);

    logic [VAL_W-1:0] w_value [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] w_lower;
        logic [VAL_W-1:0] w_upper;

        if (g == 0) begin : g_first
            assign w_lower = i_ctrl.data;
        end else begin : g_mid_lo
            assign w_lower = w_value[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_upper = w_value[g];
        end else begin : g_mid_hi
            assign w_upper = w_value[g+1];
        end

        cbd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_index (IDX_W'(g)),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_value (w_value[g])
        );
    end

    assign o_head = w_value[0];

endmodule

[rtl/core/circular_buffer_deque.sv]
// circular buffer deque top level: request decode, occupancy count and result register
//
// A double-ended queue of up to DEPTH 31-bit elements. Each request pushes or
// pops at the front or at the back and gives exactly one result: the popped
// element (zero otherwise), an empty flag for a pop that found nothing, a full
// flag for a push that was dropped, and the occupancy after the request. The
// store is two rows of identical cells. The front row keeps the front element
// in cell zero and the back row keeps the back element in cell zero; a push at
// a row's own end shifts that row up by one cell, a pop at its own end shifts
// it down, and a push at the far end is written into the first free cell, whose
// position every cell checks against the broadcast count. A pop is therefore
// always read from a fixed cell. A request is taken in every cycle in which the
// result register is empty or being drained, so the sustained rate is one
// request per clock, and each result is registered. No clearing is needed after
// reset: only cells below the count are ever read.
module circular_buffer_deque
    import cbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_mode,
    input  logic [VAL_W-1:0]  i_push_value,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [VAL_W-1:0]  o_pop_value,
    output logic              o_was_empty,
    output logic              o_was_full,
    output logic [CNT_W-1:0]  o_occupancy
);

    // control state
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    // result payload
    logic [VAL_W-1:0]  r_pop_value;
    logic [VAL_W-1:0]  n_pop_value;
    logic              r_was_empty;
    logic              n_was_empty;
    logic              r_was_full;
    logic              n_was_full;
    logic [CNT_W-1:0]  r_occupancy;

    logic              w_accept;
    logic              w_empty;
    logic              w_full;
    t_row_op           w_front_op;
    t_row_op           w_back_op;
    t_row_ctrl         w_front_ctrl;
    t_row_ctrl         w_back_ctrl;
    logic [VAL_W-1:0]  w_front_head;
    logic [VAL_W-1:0]  w_back_head;

    // a new request may enter while no result is held or the current result is being taken
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(DEPTH));

    // request decode: row operations, flags, popped element and new count
    always_comb begin
        w_front_op  = ROW_HOLD;
        w_back_op   = ROW_HOLD;
        n_pop_value = '0;
        n_was_empty = 1'b0;
        n_was_full  = 1'b0;
        n_count     = r_count;
        unique case (t_mode'(i_mode))
            MODE_PUSH_FRONT: begin
                if (w_full) begin
                    n_was_full = 1'b1;
                end else begin
                    w_front_op = ROW_INSERT;
                    w_back_op  = ROW_APPEND;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            MODE_POP_FRONT: begin
                if (w_empty) begin
                    n_was_empty = 1'b1;
                end else begin
                    // the back row just forgets its last used cell
                    w_front_op  = ROW_REMOVE;
                    n_pop_value = w_front_head;
                    n_count     = r_count - CNT_W'(1);
                end
            end
            MODE_PUSH_BACK: begin
                if (w_full) begin
                    n_was_full = 1'b1;
                end else begin
                    w_front_op = ROW_APPEND;
                    w_back_op  = ROW_INSERT;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            MODE_POP_BACK: begin
                if (w_empty) begin
                    n_was_empty = 1'b1;
                end else begin
                    w_back_op   = ROW_REMOVE;
                    n_pop_value = w_back_head;
                    n_count     = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // rows only move on an accepted request
    assign w_front_ctrl = '{op:    w_accept ? w_front_op : ROW_HOLD,
                            data:  i_push_value,
                            count: r_count};
    assign w_back_ctrl  = '{op:    w_accept ? w_back_op : ROW_HOLD,
                            data:  i_push_value,
                            count: r_count};

    cbd_row u_front_row (
        .i_clk  (i_clk),
        .i_ctrl (w_front_ctrl),
        .o_head (w_front_head)
    );

    cbd_row u_back_row (
        .i_clk  (i_clk),
        .i_ctrl (w_back_ctrl),
        .o_head (w_back_head)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register, loaded with each accepted request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_value <= n_pop_value;
            r_was_empty <= n_was_empty;
            r_was_full  <= n_was_full;
            r_occupancy <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_pop_value;
    assign o_was_empty = r_was_empty;
    assign o_was_full  = r_was_full;
    assign o_occupancy = r_occupancy;

endmodule
